/* hw/rtl/nbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Nucleotide bit-plane packer package
// Shared constants, types and the character decoder used by the front end,
// the queue and the top level.
// ----------------------------------------------------------------------------
package nbp_pkg;

   localparam int SYMBOL_BITS    = 8;
   localparam int SHIFT_BITS     = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE_COMPLEMENT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHIFT_AMOUNT       = 2'd1;

   // ASCII codes of the four bases.
   localparam logic [SYMBOL_BITS-1:0] CHAR_A = 8'h41;
   localparam logic [SYMBOL_BITS-1:0] CHAR_C = 8'h43;
   localparam logic [SYMBOL_BITS-1:0] CHAR_G = 8'h47;
   localparam logic [SYMBOL_BITS-1:0] CHAR_T = 8'h54;

   // The three plane bits that one character contributes.
   typedef struct packed {
      logic high;
      logic low;
      logic mask;
   } plane_bits_type;

   // Occupancy flags of the queue between front end and back end.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Forward coding is A=00, C=01, G=10, T=11; complement coding inverts the
   // two-bit code. Anything else is masked with both plane bits cleared.
   function automatic plane_bits_type decode_symbol(
      input logic [SYMBOL_BITS-1:0] symbol,
      input logic                   reverse_complement
   );
      plane_bits_type bits;
      logic [1:0]     code;
      logic           known;
      known = 1'b1;
      code  = 2'b00;
      unique case (symbol)
         CHAR_A: code = 2'b00;
         CHAR_C: code = 2'b01;
         CHAR_G: code = 2'b10;
         CHAR_T: code = 2'b11;
         default: known = 1'b0;
      endcase
      if (reverse_complement) begin
         code = ~code;
      end
      bits.high = known & code[1];
      bits.low  = known & code[0];
      bits.mask = ~known;
      return bits;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/nbp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Block queue
// Two-entry register FIFO that carries finished blocks from the front end to
// the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module nbp_queue #(
   parameter int WIDTH = 97
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [WIDTH-1:0]          push_data,
   input  wire logic                      pop,
   output logic [WIDTH-1:0]               head_data,
   output nbp_pkg::queue_status_type      status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/nbp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packer front end
// Decodes each character, shifts it into the three bit planes and pushes a
// block into the queue when the planes are full or the sequence ends.
// ----------------------------------------------------------------------------
module nbp_front #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [nbp_pkg::SYMBOL_BITS-1:0]    req_symbol,
   input  wire logic                               req_last_symbol,
   input  wire logic                               reverse_complement,
   input  wire nbp_pkg::queue_status_type          queue_status,
   output logic                                    push,
   output logic [3*WORD_BITS:0]                    push_data
);

   localparam int FILL_BITS = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0]   high_acc_ff, high_acc_in;
   logic [WORD_BITS-1:0]   low_acc_ff,  low_acc_in;
   logic [WORD_BITS-1:0]   mask_acc_ff, mask_acc_in;
   logic [FILL_BITS-1:0]   fill_ff,     fill_in;
   logic [FILL_BITS-1:0]   fill_next;
   logic [FILL_BITS-1:0]   align_shift;
   logic [WORD_BITS-1:0]   high_next, low_next, mask_next;
   logic                   accept;
   logic                   block_full;
   nbp_pkg::plane_bits_type bits;

   assign req_stall = queue_status.full;
   assign accept    = req_valid & ~queue_status.full;
   assign bits      = nbp_pkg::decode_symbol(req_symbol, reverse_complement);

   always_comb begin
      high_next   = {bits.high, high_acc_ff[WORD_BITS-1:1]};
      low_next    = {bits.low,  low_acc_ff[WORD_BITS-1:1]};
      mask_next   = {bits.mask, mask_acc_ff[WORD_BITS-1:1]};
      fill_next   = fill_ff + FILL_BITS'(1);
      block_full  = (fill_next == FILL_BITS'(WORD_BITS));
      align_shift = FILL_BITS'(WORD_BITS) - fill_next;

      push      = accept & (block_full | req_last_symbol);
      // A partial block at the end of a sequence is moved down so that its
      // first character sits at bit 0.
      if (block_full) begin
         push_data = {req_last_symbol, mask_next, low_next, high_next};
      end else begin
         push_data = {req_last_symbol, mask_next >> align_shift,
                      low_next >> align_shift, high_next >> align_shift};
      end

      high_acc_in = high_acc_ff;
      low_acc_in  = low_acc_ff;
      mask_acc_in = mask_acc_ff;
      fill_in     = fill_ff;
      if (accept) begin
         if (block_full | req_last_symbol) begin
            high_acc_in = '0;
            low_acc_in  = '0;
            mask_acc_in = '0;
            fill_in     = '0;
         end else begin
            high_acc_in = high_next;
            low_acc_in  = low_next;
            mask_acc_in = mask_next;
            fill_in     = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_acc_ff <= '0;
         low_acc_ff  <= '0;
         mask_acc_ff <= '0;
         fill_ff     <= '0;
      end else begin
         high_acc_ff <= high_acc_in;
         low_acc_ff  <= low_acc_in;
         mask_acc_ff <= mask_acc_in;
         fill_ff     <= fill_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/nbp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packer back end
// Takes blocks from the queue, applies the funnel shift against the previous
// block, appends the sentinel block and drives the result register.
// ----------------------------------------------------------------------------
module nbp_back #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [nbp_pkg::SHIFT_BITS-1:0]     shift_amount,
   input  wire nbp_pkg::queue_status_type          queue_status,
   input  wire logic [3*WORD_BITS:0]               head_data,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [WORD_BITS-1:0]                    rsp_high_word,
   output logic [WORD_BITS-1:0]                    rsp_low_word,
   output logic [WORD_BITS-1:0]                    rsp_mask_word,
   output logic                                    rsp_last_block
);

   localparam int SHW = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] prev_high_ff, prev_high_in;
   logic [WORD_BITS-1:0] prev_low_ff,  prev_low_in;
   logic [WORD_BITS-1:0] prev_mask_ff, prev_mask_in;
   logic                 sentinel_phase_ff, sentinel_phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] high_word_ff, high_word_in;
   logic [WORD_BITS-1:0] low_word_ff,  low_word_in;
   logic [WORD_BITS-1:0] mask_word_ff, mask_word_in;
   logic                 last_block_ff, last_block_in;
   logic [WORD_BITS-1:0] head_high, head_low, head_mask;
   logic [WORD_BITS-1:0] cur_high, cur_low, cur_mask;
   logic                 head_sentinel;
   logic [SHW-1:0]       shift_eff;
   logic                 load;

   function automatic logic [WORD_BITS-1:0] funnel(
      input logic [WORD_BITS-1:0] cur,
      input logic [WORD_BITS-1:0] prev,
      input logic [SHW-1:0]       s
   );
      logic [2*WORD_BITS-1:0] joined;
      joined = {cur, prev} << s;
      return joined[2*WORD_BITS-1:WORD_BITS];
   endfunction

   assign head_high     = head_data[WORD_BITS-1:0];
   assign head_low      = head_data[2*WORD_BITS-1:WORD_BITS];
   assign head_mask     = head_data[3*WORD_BITS-1:2*WORD_BITS];
   assign head_sentinel = head_data[3*WORD_BITS];

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_high_word  = high_word_ff;
   assign rsp_low_word   = low_word_ff;
   assign rsp_mask_word  = mask_word_ff;
   assign rsp_last_block = last_block_ff;

   always_comb begin
      if (int'(shift_amount) >= WORD_BITS) begin
         shift_eff = SHW'(WORD_BITS - 1);
      end else begin
         shift_eff = SHW'(shift_amount);
      end

      load = ~queue_status.empty & (~rsp_valid_ff | ~rsp_stall);

      // The sentinel block is all zero and follows the last data block.
      if (sentinel_phase_ff) begin
         cur_high = '0;
         cur_low  = '0;
         cur_mask = '0;
      end else begin
         cur_high = head_high;
         cur_low  = head_low;
         cur_mask = head_mask;
      end

      high_word_in      = high_word_ff;
      low_word_in       = low_word_ff;
      mask_word_in      = mask_word_ff;
      last_block_in     = last_block_ff;
      prev_high_in      = prev_high_ff;
      prev_low_in       = prev_low_ff;
      prev_mask_in      = prev_mask_ff;
      sentinel_phase_in = sentinel_phase_ff;
      pop               = 1'b0;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;

      if (load) begin
         rsp_valid_in  = 1'b1;
         high_word_in  = funnel(cur_high, prev_high_ff, shift_eff);
         low_word_in   = funnel(cur_low,  prev_low_ff,  shift_eff);
         mask_word_in  = funnel(cur_mask, prev_mask_ff, shift_eff);
         last_block_in = sentinel_phase_ff;
         if (sentinel_phase_ff) begin
            // The sequence is over: the next one starts from a zero block.
            prev_high_in      = '0;
            prev_low_in       = '0;
            prev_mask_in      = '0;
            sentinel_phase_in = 1'b0;
            pop               = 1'b1;
         end else begin
            prev_high_in      = head_high;
            prev_low_in       = head_low;
            prev_mask_in      = head_mask;
            sentinel_phase_in = head_sentinel;
            pop               = ~head_sentinel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_high_ff      <= '0;
         prev_low_ff       <= '0;
         prev_mask_ff      <= '0;
         sentinel_phase_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         prev_high_ff      <= prev_high_in;
         prev_low_ff       <= prev_low_in;
         prev_mask_ff      <= prev_mask_in;
         sentinel_phase_ff <= sentinel_phase_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_word_ff  <= high_word_in;
      low_word_ff   <= low_word_in;
      mask_word_ff  <= mask_word_in;
      last_block_ff <= last_block_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/nucleotide_bitplane_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Nucleotide bit-plane packer
// Packs a stream of ASCII nucleotides into two-bit planes with an N mask and
// a funnel shift across consecutive blocks.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle unless the queue is full: each
// request carries one ASCII character, which is decoded and shifted into the
// top bit of three planes (high, low and a mask for anything that is not A,
// C, G or T). After WORD_BITS characters, or on a request marked as the last
// of its sequence, the front end pushes a block into a two-entry queue. The
// back end shifts each block left by the configured amount, filling from the
// previous block of the same sequence, and puts one result per cycle into the
// output register unless the result channel stalls. A sequence end yields two
// results (the right-aligned final block and an all-zero sentinel with
// last_block set). A block passes through the queue and then the result
// register. Configuration registers (index 0: reverse complement coding,
// index 1: shift amount) are always ready; the user must write them only while
// the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nucleotide_bitplane_packer #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel.
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [nbp_pkg::SYMBOL_BITS-1:0]       req_symbol,
   input  wire logic                                  req_last_symbol,
   // Result channel.
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [WORD_BITS-1:0]                       rsp_high_word,
   output logic [WORD_BITS-1:0]                       rsp_low_word,
   output logic [WORD_BITS-1:0]                       rsp_mask_word,
   output logic                                       rsp_last_block,
   // Configuration write channel.
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [nbp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [nbp_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int ENTRY_BITS = 3 * WORD_BITS + 1;

   logic                              reverse_complement_ff, reverse_complement_in;
   logic [nbp_pkg::SHIFT_BITS-1:0]    shift_amount_ff, shift_amount_in;
   logic                              push;
   logic [ENTRY_BITS-1:0]             push_data;
   logic                              pop;
   logic [ENTRY_BITS-1:0]             head_data;
   nbp_pkg::queue_status_type         queue_status;

   // The configuration port never pushes back; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      reverse_complement_in = reverse_complement_ff;
      shift_amount_in       = shift_amount_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nbp_pkg::CSR_REVERSE_COMPLEMENT: reverse_complement_in = csr_wdata[0];
            nbp_pkg::CSR_SHIFT_AMOUNT:
               shift_amount_in = csr_wdata[nbp_pkg::SHIFT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_complement_ff <= 1'b0;
         shift_amount_ff       <= '0;
      end else begin
         reverse_complement_ff <= reverse_complement_in;
         shift_amount_ff       <= shift_amount_in;
      end
   end

   // The front end owns the accumulating planes and the fill count.
   nbp_front #(
      .WORD_BITS(WORD_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_symbol         (req_symbol),
      .req_last_symbol    (req_last_symbol),
      .reverse_complement (reverse_complement_ff),
      .queue_status       (queue_status),
      .push               (push),
      .push_data          (push_data)
   );

   // Each queue entry is one unshifted block plus its end-of-sequence flag.
   nbp_queue #(
      .WIDTH(ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   // The back end owns the previous block and the result register.
   nbp_back #(
      .WORD_BITS(WORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .shift_amount   (shift_amount_ff),
      .queue_status   (queue_status),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_high_word  (rsp_high_word),
      .rsp_low_word   (rsp_low_word),
      .rsp_mask_word  (rsp_mask_word),
      .rsp_last_block (rsp_last_block)
   );

endmodule
`default_nettype wire
